@@ hdl/nwrw_pkg.sv @@
// ----------------------------------------------------------------------------
// nwrw_pkg: shared types for the nearest waypoint reference window
// Item codes, the stored waypoint record and the scan pipeline control tag.
// ----------------------------------------------------------------------------
package nwrw_pkg;

  // Item codes carried on the kind port
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  // Largest number of reference points emitted per query
  localparam int unsigned HORIZON_CAP = 64;
  localparam int unsigned HORIZON_W   = 7;

  // One stored waypoint
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] h;
  } point_t;

  // Tag that travels with a point through the distance pipeline
  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

@@ hdl/nwrw_dist.sv @@
// ----------------------------------------------------------------------------
// nwrw_dist: squared distance and running minimum
// Pipelined unit that takes one stored point a cycle, forms the exact squared
// planar distance to the robot and keeps the index of the least one.
// ----------------------------------------------------------------------------
module nwrw_dist import nwrw_pkg::*; #(
  parameter int unsigned IDX_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  scan_ctl_t          in_ctl,
  input  logic [IDX_W-1:0]   in_idx,
  input  point_t             pt,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  output logic               pipe_busy,
  output logic [IDX_W-1:0]   best_idx
);

  scan_ctl_t        a_ctl;
  logic [IDX_W-1:0] a_idx;
  logic [31:0]      ax;
  logic [31:0]      ay;

  scan_ctl_t        b_ctl;
  logic [IDX_W-1:0] b_idx;
  logic [63:0]      sx;
  logic [63:0]      sy;

  logic [64:0]      best_sum;

  logic [32:0] dx_p, dx_n, dy_p, dy_n;
  logic [64:0] sum;

  // Both differences at 33 bits; the magnitude always fits in 32
  assign dx_p = {pt.x[31], pt.x} - {robot_x[31], robot_x};
  assign dx_n = {robot_x[31], robot_x} - {pt.x[31], pt.x};
  assign dy_p = {pt.y[31], pt.y} - {robot_y[31], robot_y};
  assign dy_n = {robot_y[31], robot_y} - {pt.y[31], pt.y};

  assign sum = {1'b0, sx} + {1'b0, sy};

  assign pipe_busy = a_ctl.valid | b_ctl.valid;

  // Advance the control tags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
    end else begin
      a_ctl <= in_ctl;
      b_ctl <= a_ctl;
    end
  end

  // Magnitudes, then squares, each stage registered
  always_ff @(posedge clk) begin
    a_idx <= in_idx;
    ax    <= dx_p[32] ? dx_n[31:0] : dx_p[31:0];
    ay    <= dy_p[32] ? dy_n[31:0] : dy_p[31:0];
    b_idx <= a_idx;
    sx    <= ax * ax;
    sy    <= ay * ay;
  end

  // Keep the least distance; a tie keeps the earlier index
  always_ff @(posedge clk) begin
    if (b_ctl.valid && (b_ctl.first || sum < best_sum)) begin
      best_sum <= sum;
      best_idx <= b_idx;
    end
  end

endmodule

@@ hdl/nearest_waypoint_reference_window_core.sv @@
// A query scans the stored path, then emits one result a cycle, min(horizon, 64)
//   results in all; an empty path skips the scan and echoes the robot pose.
// The scan and the emit share the one store read port, and busy stays high through both.
// Clear, append and a zero-horizon query leave busy low; results cannot be held off.
// Synchronous reset empties the path and sets horizon to 10; store contents are kept.
// ----------------------------------------------------------------------------
// nearest_waypoint_reference_window_core: path store and lookahead window
// Stores waypoints, finds the one nearest the robot and emits a window of
// reference points from there, held at the final waypoint.
// ----------------------------------------------------------------------------
module nearest_waypoint_reference_window_core import nwrw_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [15:0]   heading,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [HORIZON_W-1:0] cfg_data,
  output logic                 result_valid,
  output logic signed [31:0]   ref_x,
  output logic signed [31:0]   ref_y,
  output logic signed [15:0]   ref_heading,
  output logic [7:0]           point_index,
  output logic                 last
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned EXT_W = IDX_W + 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     point_count;
  logic [HORIZON_W-1:0] horizon;
  logic [HORIZON_W-1:0] num_out;
  logic [CNT_W-1:0]     scan_cnt;
  logic [HORIZON_W-1:0] emit_cnt;
  logic                 echo;

  logic signed [31:0]   rob_x;
  logic signed [31:0]   rob_y;
  logic signed [15:0]   rob_h;

  point_t               mem [MAX_POINTS];
  point_t               rd_data;
  logic [IDX_W-1:0]     rd_addr;
  scan_ctl_t            rd_ctl;
  scan_ctl_t            issue_ctl;
  logic [IDX_W-1:0]     rd_idx;

  logic                 e1_valid;
  logic                 e1_last;
  logic [IDX_W-1:0]     e1_idx;
  logic [IDX_W-1:0]     out_idx;
  logic [EXT_W-1:0]     out_idx_ext;

  logic                 accept;
  logic                 do_append;
  logic                 pipe_busy;
  logic [IDX_W-1:0]     best_idx;
  logic [CNT_W-1:0]     last_pt;
  logic [CNT_W:0]       emit_sum;
  logic [CNT_W:0]       emit_sel;
  logic                 emit_last;

  assign busy      = (state != ST_IDLE);
  // Hold off a horizon write while busy or while a request is being taken
  assign cfg_ready = ~busy & ~start;
  assign accept    = start & ~busy;
  assign do_append = accept && (kind == KIND_APPEND)
                     && (point_count < CNT_W'(MAX_POINTS));

  // Saturate the horizon at the window cap
  assign num_out = (horizon > HORIZON_W'(HORIZON_CAP)) ? HORIZON_W'(HORIZON_CAP) : horizon;

  // Window position, clamped at the final stored point
  assign last_pt   = point_count - CNT_W'(1);
  assign emit_sum  = (CNT_W+1)'(best_idx) + (CNT_W+1)'(emit_cnt);
  assign emit_sel  = (emit_sum > {1'b0, last_pt}) ? {1'b0, last_pt} : emit_sum;
  assign emit_last = (emit_cnt == num_out - HORIZON_W'(1));

  // Select the read address for the scan or the window
  always_comb begin
    issue_ctl = '0;
    rd_addr   = emit_sel[IDX_W-1:0];
    if (state == ST_SCAN) begin
      rd_addr         = scan_cnt[IDX_W-1:0];
      issue_ctl.valid = (scan_cnt < point_count);
      issue_ctl.first = (scan_cnt == '0);
    end
  end

  // Path store: one write port for appends, one registered read port
  always_ff @(posedge clk) begin
    if (do_append) begin
      mem[point_count[IDX_W-1:0]] <= '{x: pos_x, y: pos_y, h: heading};
    end
    rd_data <= mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  nwrw_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (rd_ctl),
    .in_idx    (rd_idx),
    .pt        (rd_data),
    .robot_x   (rob_x),
    .robot_y   (rob_y),
    .pipe_busy (pipe_busy),
    .best_idx  (best_idx)
  );

  // Sequencer, path length, horizon and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      point_count  <= '0;
      horizon      <= HORIZON_W'(10);
      scan_cnt     <= '0;
      emit_cnt     <= '0;
      echo         <= 1'b0;
      rd_ctl       <= '0;
      e1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_ctl       <= issue_ctl;
      e1_valid     <= 1'b0;
      result_valid <= e1_valid;
      if (cfg_valid && cfg_ready) begin
        horizon <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_CLEAR:  point_count <= '0;
              KIND_APPEND: begin
                if (do_append) begin
                  point_count <= point_count + CNT_W'(1);
                end
              end
              KIND_QUERY: begin
                scan_cnt <= '0;
                emit_cnt <= '0;
                echo     <= (point_count == '0);
                if (num_out != '0) begin
                  state <= (point_count == '0) ? ST_EMIT : ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (issue_ctl.valid) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end else if (!rd_ctl.valid && !pipe_busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          e1_valid <= 1'b1;
          emit_cnt <= emit_cnt + HORIZON_W'(1);
          if (emit_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!e1_valid) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Robot pose, window tags and result payload
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_QUERY) begin
      rob_x <= pos_x;
      rob_y <= pos_y;
      rob_h <= heading;
    end
    e1_last <= emit_last;
    e1_idx  <= emit_sel[IDX_W-1:0];
    if (e1_valid) begin
      ref_x       <= echo ? rob_x : rd_data.x;
      ref_y       <= echo ? rob_y : rd_data.y;
      ref_heading <= echo ? rob_h : rd_data.h;
      out_idx     <= echo ? '0 : e1_idx;
      last        <= e1_last;
    end
  end

  assign out_idx_ext = EXT_W'(out_idx);
  assign point_index = out_idx_ext[7:0];

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("path length beyond store depth");

  a_result_in_path: assert property (@(posedge clk) disable iff (rst)
    result_valid && !echo |-> CNT_W'(out_idx) < point_count)
    else $error("emitted point beyond stored path");

  a_strobe_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe outside a query");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !busy)
    else $error("block still busy after final result");
`endif

endmodule

@@ verif/nwrw_window_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwrw_window_checker: prediction and comparison for the reference window
// Watches the request, configuration and result ports of the core, keeps its
// own copy of the path and horizon, works out each query's reference window
// and compares every strobed result against the oldest predicted point.
// ----------------------------------------------------------------------------
module nwrw_window_checker import nwrw_pkg::*; #(
  parameter int unsigned PATH_CAP = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           kind,
  input  logic [31:0]          pos_x,
  input  logic [31:0]          pos_y,
  input  logic [15:0]          heading,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [HORIZON_W-1:0] cfg_data,
  input  logic                 result_valid,
  input  logic [31:0]          ref_x,
  input  logic [31:0]          ref_y,
  input  logic [15:0]          ref_heading,
  input  logic [7:0]           point_index,
  input  logic                 last,
  output int                   pending,
  output int                   mismatch_count
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] h;
    logic [7:0]  idx;
    logic        tail;
  } ref_point_t;

  // Shadow path and horizon register
  logic [31:0]          wp_x [PATH_CAP];
  logic [31:0]          wp_y [PATH_CAP];
  logic [15:0]          wp_h [PATH_CAP];
  int unsigned          path_len;
  logic [HORIZON_W-1:0] horizon_reg;

  ref_point_t window_q[$];

  initial begin
    pending        = 0;
    mismatch_count = 0;
  end

  // Exact squared planar distance: 33-bit differences, 65-bit sum
  function automatic logic [64:0] planar_dist_sq(logic [31:0] ax, logic [31:0] ay,
                                                 logic [31:0] bx, logic [31:0] by);
    logic [32:0] dx, dy, mx, my;
    dx = {ax[31], ax} - {bx[31], bx};
    dy = {ay[31], ay} - {by[31], by};
    mx = dx[32] ? -dx : dx;
    my = dy[32] ? -dy : dy;
    return 65'(mx) * 65'(mx) + 65'(my) * 65'(my);
  endfunction

  // Apply one accepted request to the shadow path; queue any window it yields
  task automatic predict_window(logic [1:0] code, logic [31:0] x, logic [31:0] y,
                                logic [15:0] h);
    int unsigned n, best, idx;
    logic [64:0] best_d, d;
    ref_point_t pt;
    n = (horizon_reg > HORIZON_CAP) ? HORIZON_CAP : horizon_reg;
    case (code)
      KIND_CLEAR: path_len = 0;
      KIND_APPEND: begin
        // drop the waypoint once the path is full
        if (path_len < PATH_CAP) begin
          wp_x[path_len] = x;
          wp_y[path_len] = y;
          wp_h[path_len] = h;
          path_len++;
        end
      end
      KIND_QUERY: begin
        if (path_len == 0) begin
          // echo the robot pose
          for (int unsigned i = 0; i < n; i++) begin
            pt = '{x: x, y: y, h: h, idx: 8'd0, tail: (i + 1 == n)};
            window_q = {window_q, pt};
          end
        end else begin
          best   = 0;
          best_d = planar_dist_sq(wp_x[0], wp_y[0], x, y);
          for (int unsigned i = 1; i < path_len; i++) begin
            d = planar_dist_sq(wp_x[i], wp_y[i], x, y);
            // strict compare keeps the lowest index on a tie
            if (d < best_d) begin
              best   = i;
              best_d = d;
            end
          end
          for (int unsigned i = 0; i < n; i++) begin
            idx = best + i;
            if (idx > path_len - 1) idx = path_len - 1;
            pt = '{x: wp_x[idx], y: wp_y[idx], h: wp_h[idx], idx: 8'(idx),
                   tail: (i + 1 == n)};
            window_q = {window_q, pt};
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string what, ref_point_t want, ref_point_t got);
    string want_s, got_s;
    mismatch_count++;
    if (mismatch_count <= 10) begin
      want_s = $sformatf("x=%h y=%h heading=%h index=%0d last=%b",
                         want.x, want.y, want.h, want.idx, want.tail);
      got_s  = $sformatf("x=%h y=%h heading=%h index=%0d last=%b",
                         got.x, got.y, got.h, got.idx, got.tail);
      $display("%0t %s: expected %s, got %s", $realtime, what, want_s, got_s);
    end
  endtask

  // Compare one strobed result with the oldest predicted point
  task automatic check_point();
    ref_point_t want, got;
    got = '{x: ref_x, y: ref_y, h: ref_heading, idx: point_index, tail: last};
    if (window_q.size() == 0) begin
      flag_mismatch("unexpected reference point", '0, got);
    end else begin
      want = window_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.h !== want.h ||
          got.idx !== want.idx || got.tail !== want.tail)
        flag_mismatch("reference point mismatch", want, got);
    end
  endtask

  // Sample every port on the rising edge, before the core updates them
  always @(posedge clk) begin
    if (rst) begin
      window_q.delete();
      path_len    = 0;
      horizon_reg = HORIZON_W'(10);
    end else begin
      if (result_valid) check_point();
      if (cfg_valid && cfg_ready) horizon_reg = cfg_data;
      if (start && !busy) predict_window(kind, pos_x, pos_y, heading);
    end
    pending <= window_q.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the reference window core
// Runs directed pose and path corners, a horizon sweep, a full-path fill and
// three random phases of clear/append/query sequences under varying sender
// gaps; a checker module beside the core predicts and compares every point.
// ----------------------------------------------------------------------------
module testbench import nwrw_pkg::*; ();

  localparam int unsigned PATH_CAP     = 256;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  // Worst query: full scan, full window and pipeline slack
  localparam int unsigned SETTLE_CYCLES = PATH_CAP + HORIZON_CAP + 40;
  localparam int unsigned PHASE_ITEMS   = 24;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           kind = KIND_CLEAR;
  logic [31:0]          pos_x = '0;
  logic [31:0]          pos_y = '0;
  logic [15:0]          heading = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [HORIZON_W-1:0] cfg_data = '0;
  logic                 result_valid;
  logic [31:0]          ref_x;
  logic [31:0]          ref_y;
  logic [15:0]          ref_heading;
  logic [7:0]           point_index;
  logic                 last;

  int          pending;
  int          mismatch_count;
  int unsigned sender_idle_pct = 23;
  int unsigned items_sent = 0;

  nearest_waypoint_reference_window_core #(.MAX_POINTS(PATH_CAP)) dut (
    .clk, .rst, .start, .busy, .kind, .pos_x, .pos_y, .heading,
    .cfg_valid, .cfg_ready, .cfg_data,
    .result_valid, .ref_x, .ref_y, .ref_heading, .point_index, .last
  );

  nwrw_window_checker #(.PATH_CAP(PATH_CAP)) u_window_check (
    .clk, .rst, .start, .busy, .kind, .pos_x, .pos_y, .heading,
    .cfg_valid, .cfg_ready, .cfg_data,
    .result_valid, .ref_x, .ref_y, .ref_heading, .point_index, .last,
    .pending, .mismatch_count
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hand one request to the core, idling at random first
  task automatic issue(input logic [1:0] code, input logic [31:0] x,
                       input logic [31:0] y, input logic [15:0] h);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    kind    <= code;
    pos_x   <= x;
    pos_y   <= y;
    heading <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (code != KIND_UNUSED) items_sent++;
  endtask

  // Hold the sender until every predicted point has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the horizon once the core has gone quiet
  task automatic set_horizon(input int unsigned value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= HORIZON_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small coordinates so that ties and near misses are common
  function automatic logic [31:0] pick_coord();
    int offset;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: begin
        offset = $urandom_range(64);
        return 32'(offset - 32);
      end
    endcase
  endfunction

  // One random burst: mostly clear, build a path, query it; some noise
  task automatic random_sequence();
    int unsigned pick, n_pts;
    pick = $urandom_range(99);
    if (pick < 8) begin
      issue(2'($urandom_range(3)), $urandom, $urandom, 16'($urandom));
    end else begin
      // broken sequences skip the clear and grow the old path
      if (pick >= 14) issue(KIND_CLEAR, $urandom, $urandom, 16'($urandom));
      n_pts = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      repeat (n_pts) issue(KIND_APPEND, pick_coord(), pick_coord(), 16'($urandom));
      repeat ($urandom_range(1, 4))
        issue(KIND_QUERY, pick_coord(), pick_coord(), 16'($urandom));
    end
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned horizon);
    int unsigned base;
    set_horizon(horizon);
    sender_idle_pct = idle_pct;
    base = items_sent;
    while (items_sent - base < PHASE_ITEMS) random_sequence();
  endtask

  // Stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty path echoes the pose; unused kind is ignored
    issue(KIND_QUERY, 32'h7fff_ffff, 32'h8000_0000, 16'h8000);
    issue(KIND_UNUSED, 32'h1234_5678, 32'h9abc_def0, 16'h7fff);
    // Corner path: opposite extremes, a duplicated origin, a mixed corner
    issue(KIND_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff);
    issue(KIND_APPEND, 32'h8000_0000, 32'h8000_0000, 16'h8000);
    issue(KIND_APPEND, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    issue(KIND_APPEND, 32'h0000_0000, 32'h0000_0000, 16'h0001);
    issue(KIND_APPEND, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    issue(KIND_QUERY, 32'h8000_0000, 32'h8000_0000, 16'h0000);
    issue(KIND_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000);
    issue(KIND_QUERY, 32'h0000_0001, 32'hffff_ffff, 16'h0000);
    issue(KIND_QUERY, 32'h7fff_ffff, 32'h8000_0000, 16'h0000);
    drain();
    issue(KIND_CLEAR, '1, '1, '1);
    issue(KIND_QUERY, 32'h0001_0000, 32'hfffe_0000, 16'h3243);

    // Horizon sweep: zero gives nothing, over the cap saturates
    set_horizon(0);
    issue(KIND_QUERY, 32'h0000_0005, 32'h0000_0007, 16'h0100);
    issue(KIND_APPEND, 32'h0000_0003, 32'h0000_0004, 16'h0200);
    issue(KIND_QUERY, 32'h0000_0005, 32'h0000_0007, 16'h0100);
    set_horizon(127);
    issue(KIND_QUERY, 32'h0000_0005, 32'h0000_0007, 16'h0100);
    issue(KIND_QUERY, 32'hdead_beef, 32'h0bad_cafe, 16'hc0de);
    set_horizon(65);
    issue(KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 16'h0000);

    // Fill the path past capacity; the overflow appends are dropped
    set_horizon(HORIZON_CAP);
    issue(KIND_CLEAR, '0, '0, '0);
    for (int unsigned i = 0; i < PATH_CAP + 2; i++)
      issue(KIND_APPEND, 32'(i << 16), 32'($urandom_range(255)), 16'($urandom));
    issue(KIND_QUERY, 32'(255 << 16), 32'd0, 16'd0);
    issue(KIND_QUERY, 32'(300 << 16), 32'd0, 16'd0);
    issue(KIND_QUERY, 32'(200 << 16), 32'd5, 16'd0);

    random_phase(23, 1);
    random_phase(86, $urandom_range(2, 63));
    random_phase(0, $urandom_range(2, 127));

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ nearest_waypoint_reference_window_core.f @@
hdl/nwrw_pkg.sv
hdl/nwrw_dist.sv
hdl/nearest_waypoint_reference_window_core.sv
verif/nwrw_window_checker.sv
verif/testbench.sv
